// ----- rtl/fpa_pkg.sv -----
package fpa_pkg;

  // Width of every operand and result port.
  localparam int IO_BITS = 32;

  // Default number format is Q16.16.
  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;

  // Operation codes on the mode port.
  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_NEG = 3'd2,
    MODE_MUL = 3'd3,
    MODE_DIV = 3'd4
  } mode_t;

  // Operation class as decided by the front end.
  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_NEG,
    K_MUL,
    K_DIV,
    K_DZ,
    K_NONE
  } kind_t;

endpackage

// ----- rtl/fpa_queue.sv -----
module fpa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/fpa_front.sv -----
module fpa_front import fpa_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [2:0]           mode,
  input  logic [IO_BITS-1:0]   operand_a,
  input  logic [IO_BITS-1:0]   operand_b,
  output logic                 full,
  output logic                 q_push,
  output logic [4*WORD_BITS:0] q_data,
  input  logic                 q_full,
  output kind_t                q_kind
);

  localparam int W = WORD_BITS;

  logic         f_valid;
  kind_t        f_kind;
  logic [W-1:0] f_a;
  logic [W-1:0] f_b;
  logic [W-1:0] f_ma;
  logic [W-1:0] f_mb;
  logic         f_neg;

  logic         accept;
  logic [W-1:0] a_w;
  logic [W-1:0] b_w;
  kind_t        kind_next;

  assign a_w    = operand_a[W-1:0];
  assign b_w    = operand_b[W-1:0];
  assign accept = push && !full;
  assign full   = f_valid && q_full;
  assign q_push = f_valid && !q_full;
  assign q_kind = f_kind;
  assign q_data = {f_a, f_b, f_ma, f_mb, f_neg};

  // Classify the request; a zero divisor is settled here.
  always_comb begin
    unique case (mode)
      MODE_ADD: kind_next = K_ADD;
      MODE_SUB: kind_next = K_SUB;
      MODE_NEG: kind_next = K_NEG;
      MODE_MUL: kind_next = K_MUL;
      MODE_DIV: kind_next = (b_w == '0) ? K_DZ : K_DIV;
      default:  kind_next = K_NONE;
    endcase
  end

  // Input register; it empties into the queue when there is room.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  // Operands and their magnitudes for the divider.
  always_ff @(posedge clk) begin
    if (accept) begin
      f_kind <= kind_next;
      f_a    <= a_w;
      f_b    <= b_w;
      f_ma   <= a_w[W-1] ? (~a_w + 1'b1) : a_w;
      f_mb   <= b_w[W-1] ? (~b_w + 1'b1) : b_w;
      f_neg  <= a_w[W-1] ^ b_w[W-1];
    end
  end

endmodule

// ----- rtl/fpa_back.sv -----
module fpa_back import fpa_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  logic [4*WORD_BITS:0] q_data,
  input  kind_t                q_kind,
  output logic                 q_pop,
  output logic                 o_push,
  output logic [IO_BITS:0]     o_data,
  input  logic                 o_full
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int Q = W + F;

  logic                  en;
  logic [W-1:0]          in_a;
  logic [W-1:0]          in_b;
  logic [W-1:0]          in_ma;
  logic [W-1:0]          in_mb;
  logic                  in_neg;

  logic                  vld  [0:Q];
  kind_t                 kd   [0:Q];
  logic [W-1:0]          res  [0:Q];
  logic [W-1:0]          rem  [0:Q];
  logic [Q-1:0]          dvd  [0:Q];
  logic [Q-1:0]          quo  [0:Q];
  logic [W-1:0]          dvs  [0:Q];
  logic                  neg  [0:Q];
  logic signed [2*W-1:0] prod;
  logic signed [2*W-1:0] prod_sh;

  logic [W-1:0]          qw;
  logic [W-1:0]          fin;

  // The whole pipeline advances together whenever the output queue has room.
  assign en     = !o_full;
  assign q_pop  = en && !q_empty;
  assign {in_a, in_b, in_ma, in_mb, in_neg} = q_data;
  assign prod_sh = prod >>> F;

  // Entry stage: simple ops finish here, the product is formed, division starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kd[0] <= q_kind;
      case (q_kind)
        K_ADD:   res[0] <= in_a + in_b;
        K_SUB:   res[0] <= in_a - in_b;
        K_NEG:   res[0] <= ~in_a + 1'b1;
        default: res[0] <= '0;
      endcase
      prod   <= $signed(in_a) * $signed(in_b);
      rem[0] <= '0;
      dvd[0] <= {in_ma, {F{1'b0}}};
      quo[0] <= '0;
      dvs[0] <= in_mb;
      neg[0] <= in_neg;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= Q; k++) begin : g_stage
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {rem[k-1], dvd[k-1][Q-1]};
    assign diff  = trial - {1'b0, dvs[k-1]};
    assign ge    = (trial >= {1'b0, dvs[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        kd[k]  <= kd[k-1];
        rem[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        dvd[k] <= {dvd[k-1][Q-2:0], 1'b0};
        quo[k] <= {quo[k-1][Q-2:0], ge};
        dvs[k] <= dvs[k-1];
        neg[k] <= neg[k-1];
        if (k == 1 && kd[k-1] == K_MUL) begin
          res[k] <= prod_sh[W-1:0];
        end else begin
          res[k] <= res[k-1];
        end
      end
    end
  end

  // Apply the quotient sign and pick the result of the last stage.
  assign qw  = quo[Q][W-1:0];
  assign fin = (kd[Q] == K_DIV) ? (neg[Q] ? (~qw + 1'b1) : qw) : res[Q];

  assign o_push = en && vld[Q];
  assign o_data = {IO_BITS'($signed(fin)), (kd[Q] == K_DZ)};

`ifndef NO_ASSERTIONS
  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[Q]))
    else $error("Last stage changed while the pipeline was stalled.");

  a_pop_enters: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> vld[0])
    else $error("Request popped from the queue did not enter the pipeline.");

  a_no_push_on_full: assert property (@(posedge clk) disable iff (rst)
    o_full |-> !o_push)
    else $error("Result pushed into a full output queue.");
`endif

endmodule

// ----- rtl/fixed_point_alu.sv -----
// Signed fixed-point ALU: add, subtract, negate, multiply and divide.
// An accepted push passes through the input register, the mid queue, the entry stage
// and the divider, which resolves one quotient bit per pipeline stage, into the
// result queue, which drives the output ports; the default format is Q16.16.
// Throughput is one request per cycle for every operation while o_full is low.
// Reset (rst, synchronous) empties the input register, both queues and the pipeline.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [2:0]                mode,
  input  logic signed [IO_BITS-1:0] operand_a,
  input  logic signed [IO_BITS-1:0] operand_b,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [IO_BITS-1:0] result,
  output logic                      divide_by_zero
);

  localparam int QW = 4 * WORD_BITS + 1 + $bits(kind_t);

  logic                 f_push;
  logic [4*WORD_BITS:0] f_data;
  kind_t                f_kind;
  logic                 m_full;
  logic                 m_empty;
  logic                 m_pop;
  logic [QW-1:0]        m_rdata;
  logic [4*WORD_BITS:0] m_data;
  kind_t                m_kind;
  logic                 o_push;
  logic [IO_BITS:0]     o_data;
  logic                 o_full;
  logic [IO_BITS:0]     o_rdata;

  // Front end: takes requests and classifies them.
  fpa_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .mode      (mode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .full      (full),
    .q_push    (f_push),
    .q_data    (f_data),
    .q_full    (m_full),
    .q_kind    (f_kind)
  );

  // Short queue between front and back.
  fpa_queue #(.WIDTH(QW), .DEPTH(2)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_kind, f_data}),
    .full  (m_full),
    .pop   (m_pop),
    .rdata (m_rdata),
    .empty (m_empty)
  );

  assign m_kind = kind_t'(m_rdata[QW-1 -: $bits(kind_t)]);
  assign m_data = m_rdata[4*WORD_BITS:0];

  // Back end: arithmetic pipeline.
  fpa_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (m_empty),
    .q_data  (m_data),
    .q_kind  (m_kind),
    .q_pop   (m_pop),
    .o_push  (o_push),
    .o_data  (o_data),
    .o_full  (o_full)
  );

  // Result queue toward the consumer.
  fpa_queue #(.WIDTH(IO_BITS + 1), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .wdata (o_data),
    .full  (o_full),
    .pop   (pop),
    .rdata (o_rdata),
    .empty (empty)
  );

  assign result         = o_rdata[IO_BITS:1];
  assign divide_by_zero = o_rdata[0];

`ifndef NO_ASSERTIONS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && divide_by_zero) |-> (result == '0))
    else $error("Divide by zero reported with a nonzero result.");
`endif

endmodule

// ----- tb/fixed_point_alu_tb.sv -----
`timescale 1ns / 1ps

module fixed_point_alu_tb;
  import fpa_pkg::*;

  localparam int WBITS = DEF_WORD_BITS;
  localparam int FBITS = DEF_FRAC_BITS;
  localparam int LATENCY = WBITS + FBITS + 4;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               dz;
  } alu_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [2:0] mode = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic pop = 1'b0;
  logic full, empty, divide_by_zero;
  logic signed [31:0] result;

  alu_req_t pending_reqs[$];
  alu_rsp_t expected_rsps[$];
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  int pop_phase = 0;

  fixed_point_alu #(.WORD_BITS(WBITS), .FRAC_BITS(FBITS)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .operand_a(operand_a), .operand_b(operand_b), .empty(empty), .pop(pop),
    .result(result), .divide_by_zero(divide_by_zero)
  );

  always #5 clk = ~clk;

  // Sign-extend the low word bits of a value.
  function automatic logic signed [63:0] wrap_to_word(logic [63:0] v);
    logic [63:0] sh;
    sh = v << (64 - WBITS);
    return $signed(sh) >>> (64 - WBITS);
  endfunction

  // Compute the fixed-point result of one request.
  function automatic alu_rsp_t alu_compute(alu_req_t r);
    logic signed [63:0] a, b, n, q, acc;
    alu_rsp_t o;
    a = wrap_to_word(64'(r.lhs));
    b = wrap_to_word(64'(r.rhs));
    acc = '0;
    o.dz = 1'b0;
    case (r.op)
      MODE_ADD: acc = a + b;
      MODE_SUB: acc = a - b;
      MODE_NEG: acc = -a;
      MODE_MUL: acc = (a * b) >>> FBITS;
      MODE_DIV: begin
        if (b == 0) begin
          o.dz = 1'b1;
        end else begin
          // Signed division in SystemVerilog truncates toward zero.
          n = a <<< FBITS;
          q = n / b;
          acc = q;
        end
      end
      default: acc = '0;
    endcase
    o.value = 32'(wrap_to_word(acc));
    return o;
  endfunction

  // Report one mismatch and count it.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_request(logic [2:0] op, logic [31:0] lhs, logic [31:0] rhs);
    alu_req_t r;
    r.op = op;
    r.lhs = lhs;
    r.rhs = rhs;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 3) << FBITS;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // Driver: offers queued requests in bursts with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_rsps.push_back(alu_compute({mode, operand_a, operand_b}));
        void'(pending_reqs.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        // The head request stays on the ports until it is accepted.
        if (push && !full) begin
          mode <= pending_reqs[0].op;
          operand_a <= pending_reqs[0].lhs;
          operand_b <= pending_reqs[0].rhs;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            // The end of a burst usually deasserts push.
            push <= ($urandom_range(0, 2) == 0);
          end else begin
            burst_left <= burst_left - 1;
            push <= 1'b1;
          end
        end else begin
          mode <= pending_reqs[0].op;
          operand_a <= pending_reqs[0].lhs;
          operand_b <= pending_reqs[0].rhs;
          push <= 1'b1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compares each popped result with the oldest expectation.
  always @(posedge clk) begin
    alu_rsp_t want;
    if (!rst && pop && !empty) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result", result, 32'h0);
      end else begin
        want = expected_rsps.pop_front();
        if (result !== want.value) report_mismatch("result", result, want.value);
        if (divide_by_zero !== want.dz)
          report_mismatch("divide_by_zero", 32'(divide_by_zero), 32'(want.dz));
      end
    end
  end

  // Receiver: stalls on its own pattern, with one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop_phase <= pop_phase + 1;
      if (pop_phase % 600 < 150) pop <= 1'b1;
      else if (pop_phase % 600 < 400) pop <= ($urandom_range(0, 3) != 0);
      else pop <= ((pop_phase / 7) % 3 != 0) && ($urandom_range(0, 1) == 1);
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [31:0] edge_vals[6];
    edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'hFFFF_0000};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, zero divisor, unused modes.
    for (int op = 0; op < 5; op++) begin
      add_request(3'(op), edge_vals[0], edge_vals[1]);
      add_request(3'(op), edge_vals[1], edge_vals[3]);
      add_request(3'(op), edge_vals[4], edge_vals[5]);
    end
    add_request(MODE_DIV, edge_vals[1], 32'h0);
    add_request(MODE_DIV, edge_vals[0], edge_vals[3]);
    add_request(MODE_MUL, edge_vals[0], edge_vals[0]);
    add_request(3'd5, 32'h1234, 32'h5678);
    add_request(3'd6, edge_vals[1], edge_vals[1]);
    add_request(3'd7, edge_vals[0], edge_vals[0]);
    add_request(MODE_DIV, 32'h0, 32'h0);

    // Wait until every request has been sent and every expected result has arrived.
    wait (pending_reqs.size() == 0 && !push);
    wait (expected_rsps.size() == 0);

    // Long receiver hold-off while the sender keeps offering.
    @(posedge clk);
    hold_cycles <= 200;
    for (int i = 0; i < 150; i++)
      add_request(3'($urandom_range(0, 4)), random_operand(), random_operand());
    wait (pending_reqs.size() == 0 && !push);

    for (int i = 0; i < 1250; i++) begin
      logic [2:0] op;
      logic [31:0] rhs;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      rhs = ($urandom_range(0, 15) == 0) ? 32'h0 : random_operand();
      add_request(op, random_operand(), rhs);
    end
    wait (pending_reqs.size() == 0 && !push);
    wait (expected_rsps.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);

    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fpa_pkg.sv
rtl/fpa_queue.sv
rtl/fpa_front.sv
rtl/fpa_back.sv
rtl/fixed_point_alu.sv
tb/fixed_point_alu_tb.sv
